/* rtl/vrg_pkg.sv */
// Package: types, constants and action codes shared by the volume ramp generator.
`timescale 1ns / 1ps
`default_nettype none

package vrg_pkg;

  // Fixed-point format of the ramp level.
  localparam int unsigned FracBits  = 24;
  localparam int unsigned VolW      = 7;
  localparam int unsigned LevelW    = VolW + FracBits;
  localparam int unsigned StepW     = 32;
  localparam int unsigned CountW    = 16;

  // Configuration register widths and indices.
  localparam int unsigned RateW     = 17;
  localparam int unsigned ChanW     = 6;
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 17;
  localparam logic [CfgIndexW-1:0] CFG_SAMPLE_RATE   = 4'd0;
  localparam logic [CfgIndexW-1:0] CFG_CHANNEL_COUNT = 4'd1;
  localparam logic [RateW-1:0]     RATE_RESET        = 17'd44100;
  localparam logic [ChanW-1:0]     CHAN_RESET        = 6'd4;

  // Divider geometry: the start numerator is at most 44 bits wide.
  localparam int unsigned DenW      = RateW + ChanW;
  localparam int unsigned ScaledW   = 26;
  localparam int unsigned NumW      = 44;
  localparam int unsigned DivCntW   = 6;
  localparam logic [DivCntW-1:0] DIV_LAST = 6'(NumW - 1);
  localparam int unsigned ProdW     = CountW + StepW;

  // 625000 * 2^FracBits / 4096 * VOLUME_MAX / 64 folds into this constant and a shift.
  localparam logic [ScaledW-1:0] STEP_SCALE = 26'd625000;

  // Commands.
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_STOP    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // Actions applied to the state when an item finishes.
  localparam int unsigned ActW = 3;
  localparam logic [ActW-1:0] ACT_KEEP       = 3'd0;
  localparam logic [ActW-1:0] ACT_START_ZERO = 3'd1;
  localparam logic [ActW-1:0] ACT_START_SAT  = 3'd2;
  localparam logic [ActW-1:0] ACT_START_DIV  = 3'd3;
  localparam logic [ActW-1:0] ACT_STOP       = 3'd4;
  localparam logic [ActW-1:0] ACT_ADV_ALL    = 3'd5;
  localparam logic [ActW-1:0] ACT_ADV_DIV    = 3'd6;
  localparam logic [ActW-1:0] ACT_ADV_PART   = 3'd7;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [VolW-1:0]   start_volume;
    logic [7:0]        ramp_code;
    logic [CountW-1:0] sample_count;
  } vrg_item_t;

  typedef struct packed {
    logic [VolW-1:0]   current_volume;
    logic [CountW-1:0] samples_stepped;
    logic              ramp_active;
  } vrg_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            prep;
    logic            div_init;
    logic            div_step;
    logic            fin;
    logic [ActW-1:0] act;
  } vrg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       decr_zero;
    logic       den_zero;
    logic       level_zero;
    logic       step_zero;
    logic       reach;
  } vrg_status_t;

endpackage

`default_nettype wire

/* rtl/vrg_datapath.sv */
// Datapath: ramp state, configuration registers, multipliers and a bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none

module vrg_datapath
  import vrg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vrg_item_t            item_i,
  input  wire vrg_cmd_t             ctl_i,
  output vrg_status_t               status_o,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  output vrg_result_t               result_o,
  output logic                      result_valid_o
);

  logic [RateW-1:0]  rate_q;
  logic [ChanW-1:0]  chan_q;
  logic [LevelW-1:0] level_q, level_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              valid_q;

  vrg_item_t         item_q;
  logic [NumW-1:0]   num_q, num_d;
  logic [DenW-1:0]   den_q;
  logic [ProdW-1:0]  prod_q;
  logic [StepW-1:0]  divisor_q;
  logic [StepW-1:0]  rem_q, rem_d;
  logic [NumW-1:0]   quo_q, quo_d;
  vrg_result_t       result_q;

  logic [5:0]        decr;
  logic [ScaledW-1:0] scaled;
  logic [StepW:0]    trial, diff;
  logic              fits;
  logic [StepW:0]    ceil_num;
  logic [CountW-1:0] stepped;
  logic [StepW-1:0]  quo_sat;

  assign decr   = item_q.ramp_code[5:0];
  assign scaled = STEP_SCALE * {{(ScaledW-6){1'b0}}, decr};

  // The divider select is a power of eight, so it becomes a shift of the numerator.
  always_comb begin
    case (item_q.ramp_code[7:6])
      2'd0:    num_d = {{(NumW-ScaledW){1'b0}}, scaled} << 18;
      2'd1:    num_d = {{(NumW-ScaledW){1'b0}}, scaled} << 15;
      2'd2:    num_d = {{(NumW-ScaledW){1'b0}}, scaled} << 12;
      default: num_d = {{(NumW-ScaledW){1'b0}}, scaled} << 9;
    endcase
  end

  // One restoring step per cycle: the remainder always stays below the divisor.
  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = trial >= {1'b0, divisor_q};
  assign rem_d = fits ? diff[StepW-1:0] : trial[StepW-1:0];
  assign quo_d = {quo_q[NumW-2:0], fits};

  assign ceil_num = {2'b00, level_q} + {1'b0, step_q} - {{StepW{1'b0}}, 1'b1};
  assign quo_sat  = (|quo_q[NumW-1:StepW]) ? {StepW{1'b1}} : quo_q[StepW-1:0];

  always_comb begin
    level_d = level_q;
    step_d  = step_q;
    stepped = '0;
    case (ctl_i.act)
      ACT_START_ZERO: begin
        level_d = {item_q.start_volume, {FracBits{1'b0}}};
        step_d  = '0;
      end
      ACT_START_SAT: begin
        level_d = {item_q.start_volume, {FracBits{1'b0}}};
        step_d  = {StepW{1'b1}};
      end
      ACT_START_DIV: begin
        level_d = {item_q.start_volume, {FracBits{1'b0}}};
        step_d  = quo_sat;
      end
      ACT_STOP: begin
        level_d = '0;
        step_d  = '0;
      end
      ACT_ADV_ALL: begin
        stepped = item_q.sample_count;
      end
      ACT_ADV_DIV: begin
        level_d = '0;
        stepped = quo_q[CountW-1:0];
      end
      ACT_ADV_PART: begin
        level_d = level_q - prod_q[LevelW-1:0];
        stepped = item_q.sample_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RESET;
      chan_q  <= CHAN_RESET;
      level_q <= '0;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_SAMPLE_RATE) begin
          rate_q <= cfg_data_i[RateW-1:0];
        end else if (cfg_index_i == CFG_CHANNEL_COUNT) begin
          chan_q <= cfg_data_i[ChanW-1:0];
        end
      end
      if (ctl_i.fin) begin
        level_q <= level_d;
        step_q  <= step_d;
      end
      valid_q <= ctl_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q <= item_i;
    end
    if (ctl_i.prep) begin
      num_q  <= num_d;
      den_q  <= {{ChanW{1'b0}}, rate_q} * {{RateW{1'b0}}, chan_q};
      prod_q <= {{StepW{1'b0}}, item_q.sample_count} * {{CountW{1'b0}}, step_q};
    end
    if (ctl_i.div_init) begin
      rem_q <= '0;
      if (item_q.cmd == CMD_START) begin
        quo_q     <= num_q;
        divisor_q <= {{(StepW-DenW){1'b0}}, den_q};
      end else begin
        quo_q     <= {{(NumW-StepW-1){1'b0}}, ceil_num};
        divisor_q <= step_q;
      end
    end else if (ctl_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (ctl_i.fin) begin
      result_q.current_volume  <= level_d[LevelW-1:FracBits];
      result_q.samples_stepped <= stepped;
      result_q.ramp_active     <= |level_d;
    end
  end

  assign status_o.cmd        = item_q.cmd;
  assign status_o.decr_zero  = decr == '0;
  assign status_o.den_zero   = (item_q.start_volume == '0) || (den_q == '0);
  assign status_o.level_zero = level_q == '0;
  assign status_o.step_zero  = step_q == '0;
  assign status_o.reach      = prod_q >= {{(ProdW-LevelW){1'b0}}, level_q};

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/vrg_ctrl.sv */
// Controller: sequences one item through operand setup, division when needed, and commit.
`timescale 1ns / 1ps
`default_nettype none

module vrg_ctrl
  import vrg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire vrg_status_t status_i,
  output vrg_cmd_t         ctl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [ActW-1:0]    act_q, act_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               need_div;

  // Pick the commit action from the item and the registered operands.
  always_comb begin
    act_d    = ACT_KEEP;
    need_div = 1'b0;
    case (status_i.cmd)
      CMD_START: begin
        if (status_i.decr_zero) begin
          act_d = ACT_START_ZERO;
        end else if (status_i.den_zero) begin
          act_d = ACT_START_SAT;
        end else begin
          act_d    = ACT_START_DIV;
          need_div = 1'b1;
        end
      end
      CMD_STOP: begin
        act_d = ACT_STOP;
      end
      CMD_ADVANCE: begin
        if (status_i.level_zero) begin
          act_d = ACT_KEEP;
        end else if (status_i.step_zero) begin
          act_d = ACT_ADV_ALL;
        end else if (status_i.reach) begin
          act_d    = ACT_ADV_DIV;
          need_div = 1'b1;
        end else begin
          act_d = ACT_ADV_PART;
        end
      end
      default: begin
        act_d = ACT_KEEP;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctl_o   = '0;
    ctl_o.act = act_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        ctl_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cnt_d = '0;
        if (need_div) begin
          ctl_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ctl_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_KEEP;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_CHECK) begin
        act_q <= act_d;
      end
    end
  end

  assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

/* rtl/volume_ramp_generator.sv */
// Top level of the volume ramp generator: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Linear volume ramp for one voice.
// A word is taken from item_i at a clock edge where start is high and busy is
// low. Commands: start loads the level from start_volume and works out the
// per-sample step; stop clears level and step; advance steps the level down
// for up to sample_count samples, stopping at zero.
// Each word gives one result on result_o, shown for exactly one cycle with
// result_valid_o high; the receiver cannot hold it off.
// An accepted word passes through operand setup, a check and the commit, and,
// when a division is needed (a start with a nonzero decrement, start volume
// and divisor, or an advance that reaches zero), through the bit-serial
// divider, one quotient bit per cycle for the 44-bit numerator. busy drops in
// the same cycle as the strobe, so the next word may be taken while a result
// is shown; no new word is taken until the last one is through.
// Configuration words (index 0 sample rate, 1 channel count) are taken on
// any cycle through cfg_valid_i/cfg_ready_o and should be written while idle.
// Reset clears level and step and loads the sample rate with 44100 and the
// channel count with 4.
module volume_ramp_generator
  import vrg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire vrg_item_t            item_i,
  output vrg_result_t               result_o,
  output logic                      result_valid_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  vrg_cmd_t    ctl;
  vrg_status_t status;

  assign cfg_ready_o = 1'b1;

  vrg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .ctl_o    (ctl)
  );

  vrg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .ctl_i          (ctl),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire
